// ===== sv/baro_pkg.sv =====
// Package: shared types and constants for the barometric compensation core.
`timescale 1ns / 1ps
`default_nettype none
package baro_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DataW    = 32;
  localparam int unsigned RawW     = 19;
  localparam int unsigned MaxShift = 16;

  localparam logic [CfgIdxW-1:0] REG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_B1_B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MC_MD   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_OSS     = 3'd5;

  localparam logic [DataW-1:0] C_4000  = 32'd4000;
  localparam logic [DataW-1:0] C_3038  = 32'd3038;
  localparam logic [DataW-1:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [DataW-1:0] C_3791  = 32'd3791;
  localparam logic [DataW-1:0] C_50000 = 32'd50000;
  localparam logic [DataW-1:0] C_32768 = 32'd32768;
  localparam logic [DataW-1:0] C_SIGN  = 32'h8000_0000;

  typedef enum logic [5:0] {
    ST_IDLE,
    // temperature
    ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
    // pressure
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
    ST_P10, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15, ST_P16, ST_P17,
    ST_P18, ST_P19,
    ST_DIVWAIT,
    ST_OUT
  } baro_state_t;

  // divider request
  typedef struct packed {
    logic             start;
    logic             sgn;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
  } baro_div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] quo;
  } baro_div_rsp_t;

endpackage : baro_pkg
`default_nettype wire

// ===== sv/baro_div.sv =====
// Serial 32-bit divider, one quotient bit per cycle, signed or unsigned.
`timescale 1ns / 1ps
`default_nettype none
module baro_div (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire baro_pkg::baro_div_req_t req,
  output baro_pkg::baro_div_rsp_t     rsp
);
  import baro_pkg::*;

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic [DataW-1:0] rem_r, rem_nxt;
  logic [DataW-1:0] quo_r, quo_nxt;
  logic [DataW-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DataW:0]   trial;
  logic [DataW-1:0] shrem;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shrem    = {rem_r[DataW-2:0], quo_r[DataW-1]};
    trial    = {1'b0, shrem} - {1'b0, den_r};
    if (req.start) begin
      // take magnitudes; remember quotient sign
      quo_nxt  = (req.sgn && req.num[DataW-1]) ? (~req.num + 1'b1) : req.num;
      den_nxt  = (req.sgn && req.den[DataW-1]) ? (~req.den + 1'b1) : req.den;
      neg_nxt  = req.sgn && (req.num[DataW-1] ^ req.den[DataW-1]);
      rem_nxt  = '0;
      cnt_nxt  = CntW'(DataW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DataW]) begin
        rem_nxt = trial[DataW-1:0];
        quo_nxt = {quo_r[DataW-2:0], 1'b1};
      end else begin
        rem_nxt = shrem;
        quo_nxt = {quo_r[DataW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule : baro_div
`default_nettype wire

// ===== sv/barometric_compensation_core.sv =====
// Top level: sequenced integer compensation for a barometric sensor.
`timescale 1ns / 1ps
`default_nettype none
// Each transfer on the in_ channel is one raw reading, tagged by in_kind as
// temperature (0) or pressure (1); each produces exactly one transfer on the
// out_ channel. A small sequencer drives one shared 32x32 multiplier (low 32
// bits kept) followed by an arithmetic right shifter, plus one serial divider
// that resolves one quotient bit per cycle; the sequencer waits on its done
// flag. An item that hits a zero divisor skips the divide. The core is not
// ready for a new item until the result has been taken. The temperature
// intermediate (B5) is kept across items and starts at zero.
// A zero divisor returns value 0 with divide_error set, and a temperature
// item that hits it leaves B5 untouched. Write the calibration registers
// only while the core is idle.
module barometric_compensation_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_kind,
  input  wire logic [baro_pkg::RawW-1:0]     in_raw_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_result_kind,
  output logic signed [baro_pkg::DataW-1:0]  out_value,
  output logic                               out_divide_error,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [baro_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [baro_pkg::DataW-1:0]    cfg_data
);
  import baro_pkg::*;

  localparam int unsigned ShW = $clog2(MaxShift + 1);

  // configuration
  logic [DataW-1:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]       oss_r;
  logic [DataW-1:0] b5_r, b5_nxt;

  // sequencer
  baro_state_t state_r, state_nxt;
  logic        kind_r;
  logic [RawW-1:0] raw_r;
  logic [DataW-1:0] acc_r, acc_nxt;   // divisor, tested for zero
  logic [DataW-1:0] a_r, a_nxt, b_r, b_nxt, c_r, c_nxt, d_r, d_nxt;
  logic [DataW-1:0] val_r, val_nxt;
  logic             err_r, err_nxt;
  logic             div_neg_r, div_neg_nxt;

  // shared multiply + shift unit operands
  logic [DataW-1:0] mul_a, mul_b, mul_p;
  logic [ShW-1:0]   sh_amt;
  logic [DataW-1:0] unit_out;
  logic [DataW-1:0] t_scaled;

  baro_div_req_t div_req;
  baro_div_rsp_t div_rsp;

  baro_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  function automatic logic [DataW-1:0] hi_s(input logic [DataW-1:0] w);
    return {{(DataW/2){w[DataW-1]}}, w[DataW-1:DataW/2]};
  endfunction
  function automatic logic [DataW-1:0] lo_s(input logic [DataW-1:0] w);
    return {{(DataW/2){w[DataW/2-1]}}, w[DataW/2-1:0]};
  endfunction
  function automatic logic [DataW-1:0] asr(input logic [DataW-1:0] v,
                                           input logic [ShW-1:0] s);
    return DataW'($signed(v) >>> s);
  endfunction

  assign mul_p    = DataW'(mul_a * mul_b);
  assign unit_out = asr(mul_p, sh_amt);

  // temperature in 0.1 degree steps, before truncation to 16 bits
  assign t_scaled = asr(a_r + c_r + 32'd8, ShW'(4));

  // config writes
  assign cfg_ready = (state_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0; ac34_r <= '0; ac56_r <= '0;
      b12_r  <= '0; mcmd_r <= '0; oss_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_AC1_AC2: ac12_r <= cfg_data;
        REG_AC3_AC4: ac34_r <= cfg_data;
        REG_AC5_AC6: ac56_r <= cfg_data;
        REG_B1_B2:   b12_r  <= cfg_data;
        REG_MC_MD:   mcmd_r <= cfg_data;
        REG_OSS:     oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = in_kind ? ST_P0 : ST_T0;
      ST_T0:      state_nxt = ST_T1;
      ST_T1:      state_nxt = ST_T2;
      ST_T2:      state_nxt = (acc_r == '0) ? ST_OUT : ST_T3;
      ST_T3:      state_nxt = ST_DIVWAIT;
      ST_T4:      state_nxt = ST_OUT;
      ST_P0:      state_nxt = ST_P1;
      ST_P1:      state_nxt = ST_P2;
      ST_P2:      state_nxt = ST_P3;
      ST_P3:      state_nxt = ST_P4;
      ST_P4:      state_nxt = ST_P5;
      ST_P5:      state_nxt = ST_P6;
      ST_P6:      state_nxt = ST_P7;
      ST_P7:      state_nxt = ST_P8;
      ST_P8:      state_nxt = ST_P9;
      ST_P9:      state_nxt = ST_P10;
      ST_P10:     state_nxt = (acc_r == '0) ? ST_OUT : ST_P11;
      ST_P11:     state_nxt = ST_DIVWAIT;
      ST_DIVWAIT: if (div_rsp.done) state_nxt = kind_r ? ST_P12 : ST_T4;
      ST_P12:     state_nxt = ST_P13;
      ST_P13:     state_nxt = ST_P14;
      ST_P14:     state_nxt = ST_P15;
      ST_P15:     state_nxt = ST_P16;
      ST_P16:     state_nxt = ST_P17;
      ST_P17:     state_nxt = ST_P18;
      ST_P18:     state_nxt = ST_P19;
      ST_P19:     state_nxt = ST_OUT;
      ST_OUT:     if (!out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath control: at most one multiply-shift per cycle
  always_comb begin
    acc_nxt = acc_r; a_nxt = a_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    val_nxt = val_r; err_nxt = err_r; b5_nxt = b5_r; div_neg_nxt = div_neg_r;
    mul_a = '0; mul_b = '0; sh_amt = '0;
    div_req = '0;
    unique case (state_r)
      ST_IDLE: begin
        err_nxt = 1'b0;
        val_nxt = '0;
      end
      // x1 = (ut - ac6) * ac5 >>> 15
      ST_T0: begin
        mul_a = {16'd0, raw_r[15:0]} - {16'd0, ac56_r[15:0]};
        mul_b = {16'd0, ac56_r[31:16]};
        sh_amt = ShW'(15);
        a_nxt = unit_out;
      end
      // mc * 2048
      ST_T1: begin
        mul_a = hi_s(mcmd_r); mul_b = 32'd2048;
        b_nxt = unit_out;
        acc_nxt = a_r + lo_s(mcmd_r);
      end
      ST_T2: if (acc_r == '0) err_nxt = 1'b1;
      ST_T3: begin
        div_req.start = 1'b1; div_req.sgn = 1'b1;
        div_req.num = b_r; div_req.den = acc_r;
      end
      ST_T4: begin
        b5_nxt = a_r + c_r;
        val_nxt = {{16{t_scaled[15]}}, t_scaled[15:0]};
      end
      // b6 = b5 - 4000 -> a
      ST_P0: a_nxt = b5_r - C_4000;
      // sq = b6*b6 >>> 12 -> b
      ST_P1: begin
        mul_a = a_r; mul_b = a_r; sh_amt = ShW'(12);
        b_nxt = unit_out;
      end
      // x1 = b2*sq >>> 11 -> c
      ST_P2: begin
        mul_a = lo_s(b12_r); mul_b = b_r; sh_amt = ShW'(11);
        c_nxt = unit_out;
      end
      // x3 = x1 + ac2*b6 >>> 11 -> c
      ST_P3: begin
        mul_a = lo_s(ac12_r); mul_b = a_r; sh_amt = ShW'(11);
        c_nxt = c_r + unit_out;
      end
      // b3 -> d
      ST_P4: begin
        mul_a = hi_s(ac12_r); mul_b = 32'd4;
        d_nxt = asr(((unit_out + c_r) << oss_r) + 32'd2, ShW'(2));
      end
      // x1' = ac3*b6 >>> 13 -> c
      ST_P5: begin
        mul_a = hi_s(ac34_r); mul_b = a_r; sh_amt = ShW'(13);
        c_nxt = unit_out;
      end
      // x3' = (x1' + b1*sq >>> 16 + 2) >>> 2 -> c
      ST_P6: begin
        mul_a = hi_s(b12_r); mul_b = b_r; sh_amt = ShW'(16);
        c_nxt = asr(c_r + unit_out + 32'd2, ShW'(2));
      end
      // b4 = ac4*(x3+32768) >> 15 -> b
      ST_P7: begin
        mul_a = {16'd0, ac34_r[15:0]}; mul_b = c_r + C_32768;
        b_nxt = mul_p >> 15;
      end
      // b7 = (raw - b3) * (50000 >> oss) -> c
      ST_P8: begin
        mul_a = {13'd0, raw_r} - d_r; mul_b = C_50000 >> oss_r;
        c_nxt = mul_p;
      end
      ST_P9: acc_nxt = b_r;
      ST_P10: if (acc_r == '0) err_nxt = 1'b1;
      // branch on b7 sign bit
      ST_P11: begin
        div_req.start = 1'b1; div_req.sgn = 1'b0; div_req.den = b_r;
        div_neg_nxt = (c_r >= C_SIGN);
        div_req.num = (c_r < C_SIGN) ? (c_r << 1) : c_r;
      end
      ST_DIVWAIT: if (div_rsp.done) begin
        if (kind_r) a_nxt = div_neg_r ? (div_rsp.quo << 1) : div_rsp.quo;
        else c_nxt = div_rsp.quo;
      end
      // ps = p >>> 8 -> b
      ST_P12: b_nxt = asr(a_r, ShW'(8));
      ST_P13: begin
        mul_a = b_r; mul_b = b_r;
        b_nxt = mul_p;
      end
      ST_P14: begin
        mul_a = b_r; mul_b = C_3038; sh_amt = ShW'(16);
        c_nxt = unit_out;
      end
      ST_P15: begin
        mul_a = C_M7357; mul_b = a_r; sh_amt = ShW'(16);
        c_nxt = c_r + unit_out;
      end
      ST_P16: c_nxt = c_r + C_3791;
      ST_P17: c_nxt = asr(c_r, ShW'(4));
      ST_P18: a_nxt = a_r + c_r;
      ST_P19: val_nxt = a_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      b5_r    <= '0;
    end else begin
      state_r <= state_nxt;
      b5_r    <= b5_nxt;
    end
    if (state_r == ST_IDLE && in_valid) begin
      kind_r <= in_kind;
      raw_r  <= in_raw_value;
    end
    acc_r <= acc_nxt; a_r <= a_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
    val_r <= val_nxt; err_r <= err_nxt; div_neg_r <= div_neg_nxt;
  end

  assign out_valid        = (state_r == ST_OUT);
  assign out_result_kind  = kind_r;
  assign out_value        = err_r ? '0 : val_r;
  assign out_divide_error = err_r;

  // not ready for input while a result is pending
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // temperature divide error leaves B5 untouched
  a_b5_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_error) |-> $stable(b5_r))
    else $error("B5 changed on error");

  // a divide error always reports zero
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_error) |-> (out_value == '0))
    else $error("error result not zero");

  // divider completes only while waiting on it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVWAIT))
    else $error("stray divider completion");

  // config port closed while a result is pending
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !out_valid)
    else $error("config open while busy");

endmodule : barometric_compensation_core
`default_nettype wire

// ===== sim/tb_barometric_compensation_core.sv =====
// Testbench for the barometric compensation core: predicted results vs. DUT.
`timescale 1ns / 1ps
`default_nettype none
// Drive raw temperature and pressure readings through the core under several
// calibration settings. A local predictor of the compensation math keeps its
// own copy of the registers and of the stored temperature intermediate (B5),
// queues the expected result for each accepted transfer, and a checker
// compares every output transfer field by field against the oldest entry.
// Both channels see random gaps: mostly short, a few long, with quiet
// stretches where no idling happens at all.
module tb_barometric_compensation_core;
  import baro_pkg::*;

  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic             kind;
    logic [DataW-1:0] value;
    logic             div_err;
  } reading_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_kind;
  logic [RawW-1:0]        in_raw_value;
  logic                   out_valid;
  logic                   out_stall;
  logic                   out_result_kind;
  logic signed [DataW-1:0] out_value;
  logic                   out_divide_error;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CfgIdxW-1:0]     cfg_index;
  logic [DataW-1:0]       cfg_data;

  barometric_compensation_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_raw_value(in_raw_value),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_kind(out_result_kind),
    .out_value(out_value), .out_divide_error(out_divide_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the calibration and the kept B5.
  logic [DataW-1:0] sh_ac1_ac2, sh_ac3_ac4, sh_ac5_ac6, sh_b1_b2, sh_mc_md;
  logic [1:0]       sh_oss;
  logic [DataW-1:0] sh_b5;

  reading_t expected_readings[$];
  int       mismatches;
  int       cycles;
  bit       quiet_mode;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] sar(input logic [DataW-1:0] v, input int s);
    sar = $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [DataW-1:0] sx16(input logic [15:0] h);
    sx16 = {{16{h[15]}}, h};
  endfunction

  // Work out one compensated reading and update B5 as the core would.
  function automatic reading_t compensate(input logic kind, input logic [RawW-1:0] raw);
    reading_t r;
    logic [DataW-1:0] ut, x1, x2, x3, den, b6, sq, b3, b4, b7, p, ps, t;
    logic [DataW-1:0] ac1, ac2, ac3, ac4, b1, b2;
    r.kind = kind;
    r.value = '0;
    r.div_err = 1'b0;
    if (!kind) begin
      ut = {16'd0, raw[15:0]};
      x1 = sar((ut - {16'd0, sh_ac5_ac6[15:0]}) * {16'd0, sh_ac5_ac6[31:16]}, 15);
      den = x1 + sx16(sh_mc_md[15:0]);
      if (den == '0) begin
        r.div_err = 1'b1;
      end else begin
        x2 = $unsigned($signed(sx16(sh_mc_md[31:16]) * 32'd2048) / $signed(den));
        sh_b5 = x1 + x2;
        t = sar(sh_b5 + 32'd8, 4);
        r.value = sx16(t[15:0]);
      end
    end else begin
      ac1 = sx16(sh_ac1_ac2[31:16]);
      ac2 = sx16(sh_ac1_ac2[15:0]);
      ac3 = sx16(sh_ac3_ac4[31:16]);
      ac4 = {16'd0, sh_ac3_ac4[15:0]};
      b1  = sx16(sh_b1_b2[31:16]);
      b2  = sx16(sh_b1_b2[15:0]);
      b6 = sh_b5 - C_4000;
      sq = sar(b6 * b6, 12);
      x1 = sar(b2 * sq, 11);
      x2 = sar(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sar(((ac1 * 32'd4 + x3) << sh_oss) + 32'd2, 2);
      x1 = sar(ac3 * b6, 13);
      x2 = sar(b1 * sq, 16);
      x3 = sar(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + C_32768)) >> 15;
      b7 = ({13'd0, raw} - b3) * (C_50000 >> sh_oss);
      if (b4 == '0) begin
        r.div_err = 1'b1;
      end else begin
        if (b7 < C_SIGN) p = (b7 << 1) / b4;
        else p = (b7 / b4) << 1;
        ps = sar(p, 8);
        x1 = sar((ps * ps) * C_3038, 16);
        x2 = sar(C_M7357 * p, 16);
        p = p + sar(x1 + x2 + C_3791, 4);
        r.value = p;
      end
    end
    return r;
  endfunction

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet_mode || pick < 55) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Result channel: random stall, check at the rising edge.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d value=%0d err=%0d",
                   out_result_kind, out_value, out_divide_error);
      end else begin
        want = expected_readings.pop_front();
        if (want.kind !== out_result_kind || want.value !== out_value ||
            want.div_err !== out_divide_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d value=%0d err=%0d, got kind=%0d value=%0d err=%0d",
                     want.kind, $signed(want.value), want.div_err,
                     out_result_kind, out_value, out_divide_error);
        end
      end
    end
  end

  // Stall pattern for the result channel, changed at the falling edge.
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      n = gap_length();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // Valid drops between items, so each falling edge carries a single update
  // of in_valid.
  task automatic send_reading(input logic kind, input logic [RawW-1:0] raw);
    int n;
    n = gap_length();
    repeat (n + 1) @(negedge clk);
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_raw_value <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer accepted at this edge
    expected_readings.push_back(compensate(kind, raw));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_AC1_AC2: sh_ac1_ac2 = data;
      REG_AC3_AC4: sh_ac3_ac4 = data;
      REG_AC5_AC6: sh_ac5_ac6 = data;
      REG_B1_B2:   sh_b1_b2   = data;
      REG_MC_MD:   sh_mc_md   = data;
      REG_OSS:     sh_oss     = data[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every expected result has come back, then let the core settle.
  task automatic drain();
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_calibration(input logic [DataW-1:0] w0, w1, w2, w3, w4,
                                  input logic [1:0] oss);
    drain();
    write_reg(REG_AC1_AC2, w0);
    write_reg(REG_AC3_AC4, w1);
    write_reg(REG_AC5_AC6, w2);
    write_reg(REG_B1_B2, w3);
    write_reg(REG_MC_MD, w4);
    write_reg(REG_OSS, {30'd0, oss});
  endtask

  // Typical datasheet-like calibration words.
  task automatic load_typical(input logic [1:0] oss);
    load_calibration({16'd408, 16'hFFB9}, {16'hC6B3, 16'd32741}, {16'd32757, 16'd23153},
                     {16'd6190, 16'd4}, {16'hD4BD, 16'd2868}, oss);
  endtask

  task automatic test_after_reset();
    // All-zero calibration: temperature divides by zero, pressure too.
    send_reading(1'b1, 19'd23843);
    send_reading(1'b0, 19'd27898);
    send_reading(1'b1, '1);
  endtask

  task automatic test_directed();
    load_typical(2'd0);
    send_reading(1'b1, 19'd23843);      // pressure with B5 still zero
    send_reading(1'b0, 19'd27898);
    send_reading(1'b1, 19'd23843);
    send_reading(1'b0, '0);
    send_reading(1'b0, 19'h0FFFF);
    send_reading(1'b0, '1);             // upper bits ignored for temperature
    send_reading(1'b1, '0);
    send_reading(1'b1, '1);
    send_reading(1'b0, 19'h5AAAA);
    send_reading(1'b1, 19'h2AAAA);
    load_typical(2'd3);
    send_reading(1'b0, 19'd27898);
    send_reading(1'b1, 19'd190000);
    send_reading(1'b1, '1);
    // md = -x1 forces a zero temperature divisor; B5 must stay as it was.
    load_calibration({16'd408, 16'hFFB9}, {16'hC6B3, 16'd0}, {16'd0, 16'd0},
                     {16'd6190, 16'd4}, {16'hD4BD, 16'd0}, 2'd1);
    send_reading(1'b0, 19'd1234);
    send_reading(1'b1, 19'd40000);      // ac4 zero: pressure divisor zero
    // Extremes of every word.
    load_calibration('1, '1, '1, '1, '1, 2'd2);
    send_reading(1'b0, 19'h0FFFF);
    send_reading(1'b1, '1);
    load_calibration(32'h8000_8000, 32'h8000_FFFF, 32'hFFFF_0001, 32'h8000_7FFF,
                     32'h7FFF_8000, 2'd3);
    send_reading(1'b0, '0);
    send_reading(1'b1, '0);
    send_reading(1'b1, '1);
  endtask

  task automatic random_batch(input int count);
    logic k;
    logic [RawW-1:0] raw;
    for (int i = 0; i < count; i++) begin
      if ((i % 60) == 0) quiet_mode = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 2) != 0;
      raw = RawW'($urandom());
      send_reading(k, raw);
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_random_typical();
    for (int s = 0; s < 4; s++) begin
      load_typical(s[1:0]);
      random_batch(100);
    end
  endtask

  task automatic test_random_calibration();
    for (int s = 0; s < 8; s++) begin
      load_calibration($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       2'($urandom_range(0, 3)));
      random_batch(55);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    mismatches = 0;
    quiet_mode = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_raw_value = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sh_ac1_ac2 = '0; sh_ac3_ac4 = '0; sh_ac5_ac6 = '0;
    sh_b1_b2 = '0; sh_mc_md = '0; sh_oss = '0; sh_b5 = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_after_reset();
    test_directed();
    test_random_typical();
    test_random_calibration();
    drain();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
